FILE: src/gst_pkg.sv
// shared constants, codes and types for the generational slot table
// no dependencies
package gst_pkg;

    localparam int NUM_SLOTS    = 1024;
    localparam int GEN_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int SLOT_W       = $clog2(NUM_SLOTS);
    localparam int CNT_W        = SLOT_W + 1;

    // operation codes
    localparam logic [1:0] FUNC_CREATE = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_UPDATE = 2'd2;
    localparam logic [1:0] FUNC_LOOKUP = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD1  = 4'b0010,
        S_RD2  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    // one result item
    typedef struct packed {
        logic [1:0]              status;
        logic [SLOT_W-1:0]       slot;
        logic [GEN_BITS-1:0]     gen;
        logic [SLOT_W-1:0]       pos;
        logic [PAYLOAD_BITS-1:0] payload;
    } result_t;

endpackage

FILE: src/generational_slot_table.sv
// generational handle table with packed dense record store
// sequence: idle, first read, second read (reused-slot create, remove, lookup), done,
// output register; update, fresh create, invalid handle and table full skip the second read
// a request is taken only in idle, after the last result went to the output register,
// as the dependent reads of the slot, dense and free-stack memories share single ports
// reset: synchronous active-low aresetn clears counters, sequencer and output valid;
// memories are not cleared, the issued-slot count guards never-written entries
module generational_slot_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // handle_slot, handle_gen, payload_in, zero pad
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // out_slot, out_gen, dense_pos, payload_out,
                                   // live_total, zero pad
    output logic [1:0]  m_tuser    // status
);

    localparam int SW = gst_pkg::SLOT_W;
    localparam int CW = gst_pkg::CNT_W;
    localparam int GW = gst_pkg::GEN_BITS;
    localparam int PW = gst_pkg::PAYLOAD_BITS;
    localparam int N  = gst_pkg::NUM_SLOTS;

    // input fields
    logic [SW-1:0] in_slot;
    logic [GW-1:0] in_gen;
    logic [PW-1:0] in_pay;
    assign in_slot = s_tdata[SW-1:0];
    assign in_gen  = s_tdata[SW+GW-1:SW];
    assign in_pay  = s_tdata[SW+GW+PW-1:SW+GW];

    gst_pkg::state_t state_reg, state_next;
    logic [1:0]    func_reg, func_next;
    logic [SW-1:0] hslot_reg, hslot_next;
    logic [GW-1:0] hgen_reg, hgen_next;
    logic [PW-1:0] pay_reg, pay_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [SW-1:0] pos_reg, pos_next;
    logic [CW-1:0] issued_reg, issued_next;
    logic [CW-1:0] fd_reg, fd_next;
    logic [CW-1:0] dc_reg, dc_next;
    gst_pkg::result_t res_reg, res_next;
    logic          m_valid_reg;
    gst_pkg::result_t m_res_reg;
    logic [CW-1:0] m_live_reg;

    // memory ports
    logic          gen_we, dpos_we, live_we, pay_we, own_we, free_we;
    logic [SW-1:0] gen_a, dpos_a, live_a, pay_a, own_a, free_a;
    logic [GW-1:0] gen_wd, gen_rd;
    logic [SW-1:0] dpos_wd, dpos_rd;
    logic          live_wd, live_rd;
    logic [PW-1:0] pay_wd, pay_rd;
    logic [SW-1:0] own_wd, own_rd;
    logic [SW-1:0] free_wd, free_rd;

    gst_ram #(.DEPTH(N), .WIDTH(GW)) u_gen (
        .aclk(aclk), .we(gen_we), .addr(gen_a), .wdata(gen_wd), .rdata(gen_rd));
    gst_ram #(.DEPTH(N), .WIDTH(SW)) u_dpos (
        .aclk(aclk), .we(dpos_we), .addr(dpos_a), .wdata(dpos_wd), .rdata(dpos_rd));
    gst_ram #(.DEPTH(N), .WIDTH(1)) u_live (
        .aclk(aclk), .we(live_we), .addr(live_a), .wdata(live_wd), .rdata(live_rd));
    gst_ram #(.DEPTH(N), .WIDTH(PW)) u_pay (
        .aclk(aclk), .we(pay_we), .addr(pay_a), .wdata(pay_wd), .rdata(pay_rd));
    gst_ram #(.DEPTH(N), .WIDTH(SW)) u_own (
        .aclk(aclk), .we(own_we), .addr(own_a), .wdata(own_wd), .rdata(own_rd));
    gst_ram #(.DEPTH(N), .WIDTH(SW)) u_free (
        .aclk(aclk), .we(free_we), .addr(free_a), .wdata(free_wd), .rdata(free_rd));

    logic          handle_ok;
    logic [CW-1:0] last_cnt;
    logic [CW-1:0] fd_dec;
    assign handle_ok = ({1'b0, hslot_reg} < issued_reg) && live_rd && (gen_rd == hgen_reg);
    assign last_cnt  = dc_reg - CW'(1);
    assign fd_dec    = fd_reg - CW'(1);

    assign s_tready = (state_reg == gst_pkg::S_IDLE);

    // sequencer and memory control
    always_comb begin
        state_next  = state_reg;
        func_next   = func_reg;
        hslot_next  = hslot_reg;
        hgen_next   = hgen_reg;
        pay_next    = pay_reg;
        slot_next   = slot_reg;
        pos_next    = pos_reg;
        issued_next = issued_reg;
        fd_next     = fd_reg;
        dc_next     = dc_reg;
        res_next    = res_reg;
        gen_we  = 1'b0; gen_a  = hslot_reg; gen_wd  = '0;
        dpos_we = 1'b0; dpos_a = hslot_reg; dpos_wd = '0;
        live_we = 1'b0; live_a = hslot_reg; live_wd = 1'b0;
        pay_we  = 1'b0; pay_a  = pos_reg;   pay_wd  = pay_reg;
        own_we  = 1'b0; own_a  = pos_reg;   own_wd  = '0;
        free_we = 1'b0; free_a = fd_dec[SW-1:0]; free_wd = hslot_reg;
        case (state_reg)
            gst_pkg::S_IDLE: begin
                gen_a  = in_slot;
                dpos_a = in_slot;
                live_a = in_slot;
                if (s_tvalid) begin
                    func_next  = s_tuser;
                    hslot_next = in_slot;
                    hgen_next  = in_gen;
                    pay_next   = in_pay;
                    state_next = gst_pkg::S_RD1;
                end
            end
            gst_pkg::S_RD1: begin
                state_next = gst_pkg::S_DONE;
                res_next   = '{status: gst_pkg::ST_OK, slot: hslot_reg, gen: hgen_reg,
                               pos: dpos_rd, payload: '0};
                if (func_reg == gst_pkg::FUNC_CREATE) begin
                    if (fd_reg != '0) begin
                        // reuse a freed slot, fetch its generation
                        slot_next  = free_rd;
                        gen_a      = free_rd;
                        state_next = gst_pkg::S_RD2;
                    end else if (issued_reg < CW'(N)) begin
                        // fresh slot with generation one
                        gen_we  = 1'b1; gen_a  = issued_reg[SW-1:0]; gen_wd = GW'(1);
                        dpos_we = 1'b1; dpos_a = issued_reg[SW-1:0];
                        dpos_wd = dc_reg[SW-1:0];
                        live_we = 1'b1; live_a = issued_reg[SW-1:0]; live_wd = 1'b1;
                        pay_we  = 1'b1; pay_a  = dc_reg[SW-1:0];
                        own_we  = 1'b1; own_a  = dc_reg[SW-1:0];
                        own_wd  = issued_reg[SW-1:0];
                        issued_next = issued_reg + CW'(1);
                        dc_next     = dc_reg + CW'(1);
                        res_next = '{status: gst_pkg::ST_OK, slot: issued_reg[SW-1:0],
                                     gen: GW'(1), pos: dc_reg[SW-1:0], payload: '0};
                    end else begin
                        res_next = '{status: gst_pkg::ST_FULL, slot: '0, gen: '0,
                                     pos: '0, payload: '0};
                    end
                end else if (!handle_ok) begin
                    res_next = '{status: gst_pkg::ST_INVALID, slot: hslot_reg,
                                 gen: hgen_reg, pos: '0, payload: '0};
                end else begin
                    pos_next = dpos_rd;
                    case (func_reg)
                        gst_pkg::FUNC_REMOVE: begin
                            // fetch the last dense record
                            pay_a      = last_cnt[SW-1:0];
                            own_a      = last_cnt[SW-1:0];
                            state_next = gst_pkg::S_RD2;
                        end
                        gst_pkg::FUNC_UPDATE: begin
                            pay_we = 1'b1;
                            pay_a  = dpos_rd;
                        end
                        default: begin
                            pay_a      = dpos_rd;
                            state_next = gst_pkg::S_RD2;
                        end
                    endcase
                end
            end
            gst_pkg::S_RD2: begin
                state_next = gst_pkg::S_DONE;
                case (func_reg)
                    gst_pkg::FUNC_CREATE: begin
                        // raise generation and append to dense store
                        gen_we  = 1'b1; gen_a  = slot_reg; gen_wd = gen_rd + GW'(1);
                        dpos_we = 1'b1; dpos_a = slot_reg; dpos_wd = dc_reg[SW-1:0];
                        live_we = 1'b1; live_a = slot_reg; live_wd = 1'b1;
                        pay_we  = 1'b1; pay_a  = dc_reg[SW-1:0];
                        own_we  = 1'b1; own_a  = dc_reg[SW-1:0]; own_wd = slot_reg;
                        fd_next = fd_dec;
                        dc_next = dc_reg + CW'(1);
                        res_next = '{status: gst_pkg::ST_OK, slot: slot_reg,
                                     gen: gen_rd + GW'(1), pos: dc_reg[SW-1:0],
                                     payload: '0};
                    end
                    gst_pkg::FUNC_REMOVE: begin
                        // move last record into the hole and free the slot
                        if (pos_reg != last_cnt[SW-1:0]) begin
                            pay_we  = 1'b1; pay_a = pos_reg; pay_wd = pay_rd;
                            own_we  = 1'b1; own_a = pos_reg; own_wd = own_rd;
                            dpos_we = 1'b1; dpos_a = own_rd; dpos_wd = pos_reg;
                        end
                        live_we = 1'b1; live_a = hslot_reg; live_wd = 1'b0;
                        free_we = 1'b1; free_a = fd_reg[SW-1:0]; free_wd = hslot_reg;
                        fd_next = fd_reg + CW'(1);
                        dc_next = last_cnt;
                        res_next = '{status: gst_pkg::ST_OK, slot: hslot_reg,
                                     gen: hgen_reg, pos: pos_reg, payload: '0};
                    end
                    default: begin
                        res_next = '{status: gst_pkg::ST_OK, slot: hslot_reg,
                                     gen: hgen_reg, pos: pos_reg, payload: pay_rd};
                    end
                endcase
            end
            gst_pkg::S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = gst_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = gst_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gst_pkg::S_IDLE;
            issued_reg  <= '0;
            fd_reg      <= '0;
            dc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            fd_reg     <= fd_next;
            dc_reg     <= dc_next;
            if (state_reg == gst_pkg::S_DONE && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        func_reg  <= func_next;
        hslot_reg <= hslot_next;
        hgen_reg  <= hgen_next;
        pay_reg   <= pay_next;
        slot_reg  <= slot_next;
        pos_reg   <= pos_next;
        res_reg   <= res_next;
        if (state_reg == gst_pkg::S_DONE && (!m_valid_reg || m_tready)) begin
            m_res_reg  <= res_reg;
            m_live_reg <= dc_reg;
        end
    end

    // output packing
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {1'b0, m_live_reg, m_res_reg.payload, m_res_reg.pos,
                       m_res_reg.gen, m_res_reg.slot};

endmodule

FILE: src/gst_ram.sv
// single-port synchronous ram, read-first, registered read
// no dependencies
module gst_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: tb/tb_top.sv
// self-checking bench for the generational slot table
// depends on gst_pkg and generational_slot_table
module tb_top;

    localparam int HOLD_OFF_LEN = 200;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // handle_slot, handle_gen, payload_in, zero pad
    logic [1:0]  s_tuser;   // func
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // out_slot, out_gen, dense_pos, payload_out, live_total, pad
    logic [1:0]  m_tuser;   // status

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  slot;
        logic [15:0] gen;
        logic [9:0]  pos;
        logic [31:0] payload;
        logic [10:0] live;
    } outcome_t;

    // local copy of the table
    logic [15:0] tbl_gen[gst_pkg::NUM_SLOTS];
    logic [9:0]  tbl_pos[gst_pkg::NUM_SLOTS];
    bit          tbl_live[gst_pkg::NUM_SLOTS];
    logic [10:0] tbl_issued;
    logic [9:0]  tbl_free[gst_pkg::NUM_SLOTS];
    logic [10:0] tbl_free_depth;
    logic [31:0] tbl_payload[gst_pkg::NUM_SLOTS];
    logic [9:0]  tbl_owner[gst_pkg::NUM_SLOTS];
    logic [10:0] tbl_count;

    outcome_t    pending_outcomes[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          sender_idle_pct;
    int          receiver_stall_pct;
    bit          hold_off_go;
    bit          hold_off_used;
    int          hold_off_cycles = 0;

    generational_slot_table DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #4 aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    // predict the result of one request and advance the table copy
    function automatic outcome_t table_apply(logic [1:0] func, logic [9:0] hs,
                                             logic [15:0] hg, logic [31:0] pay);
        outcome_t   o;
        logic [9:0] slot;
        logic [9:0] pos;
        logic [9:0] last;
        logic [9:0] mover;
        o = '0;
        if (func == gst_pkg::FUNC_CREATE) begin
            if (tbl_free_depth != 11'd0) begin
                tbl_free_depth = tbl_free_depth - 11'd1;
                slot = tbl_free[tbl_free_depth[9:0]];
                tbl_gen[slot] = tbl_gen[slot] + 16'd1;
            end else if (tbl_issued < 11'(gst_pkg::NUM_SLOTS)) begin
                slot = tbl_issued[9:0];
                tbl_issued = tbl_issued + 11'd1;
                tbl_gen[slot] = 16'd1;
            end else begin
                o.status = gst_pkg::ST_FULL;
                o.live = tbl_count;
                return o;
            end
            pos = tbl_count[9:0];
            tbl_count = tbl_count + 11'd1;
            tbl_payload[pos] = pay;
            tbl_owner[pos] = slot;
            tbl_pos[slot] = pos;
            tbl_live[slot] = 1'b1;
            o.status = gst_pkg::ST_OK; o.slot = slot; o.gen = tbl_gen[slot]; o.pos = pos;
            o.live = tbl_count;
            return o;
        end
        // handle check
        if ({1'b0, hs} >= tbl_issued || !tbl_live[hs] || hg != tbl_gen[hs]) begin
            o.status = gst_pkg::ST_INVALID; o.slot = hs; o.gen = hg; o.live = tbl_count;
            return o;
        end
        slot = hs;
        pos = tbl_pos[slot];
        o.status = gst_pkg::ST_OK; o.slot = hs; o.gen = hg; o.pos = pos;
        if (func == gst_pkg::FUNC_REMOVE) begin
            last = tbl_count[9:0] - 10'd1;
            if (pos != last) begin
                mover = tbl_owner[last];
                tbl_payload[pos] = tbl_payload[last];
                tbl_owner[pos] = mover;
                tbl_pos[mover] = pos;
            end
            tbl_count = tbl_count - 11'd1;
            tbl_live[slot] = 1'b0;
            tbl_free[tbl_free_depth[9:0]] = slot;
            tbl_free_depth = tbl_free_depth + 11'd1;
        end else if (func == gst_pkg::FUNC_UPDATE) begin
            tbl_payload[pos] = pay;
        end else begin
            o.payload = tbl_payload[pos];
        end
        o.live = tbl_count;
        return o;
    endfunction

    // send one request, predicting at acceptance
    task automatic send_request(logic [1:0] func, logic [9:0] hs, logic [15:0] hg,
                                logic [31:0] pay);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {6'd0, pay, hg, hs};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_outcomes = {pending_outcomes, table_apply(func, hs, hg, pay)};
    endtask

    // pick a live slot, or any slot when none
    task automatic pick_handle(output logic [9:0] hs, output logic [15:0] hg);
        logic [9:0] idx;
        hs = '0; hg = '0;
        if (tbl_count != 11'd0) begin
            idx = 10'($urandom_range(32'(tbl_count - 11'd1)));
            hs = tbl_owner[idx]; hg = tbl_gen[hs];
        end else if (tbl_issued != 11'd0) begin
            hs = 10'($urandom_range(32'(tbl_issued - 11'd1)));
            hg = tbl_gen[hs];
        end
    endtask

    task automatic random_op(int create_pct);
        logic [9:0]  hs;
        logic [15:0] hg;
        int          r;
        pick_handle(hs, hg);
        r = int'($urandom_range(99));
        // a few stale or noisy handles
        if ($urandom_range(9) == 0) hg = 16'($urandom);
        if ($urandom_range(19) == 0) hs = 10'($urandom);
        if (r < create_pct)
            send_request(gst_pkg::FUNC_CREATE, 10'($urandom), 16'($urandom), $urandom);
        else send_request(2'($urandom_range(3, 1)), hs, hg, $urandom);
    endtask

    // stop offering and wait for every result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
    endtask

    // extremes, every operation and invalid handles
    task automatic test_directed();
        send_request(gst_pkg::FUNC_LOOKUP, 10'd0, 16'd0, 32'd0);
        send_request(gst_pkg::FUNC_REMOVE, 10'h3FF, 16'hFFFF, 32'hFFFFFFFF);
        send_request(gst_pkg::FUNC_CREATE, 10'h3FF, 16'hFFFF, 32'hFFFFFFFF);
        send_request(gst_pkg::FUNC_CREATE, 10'd0, 16'd0, 32'h0);
        send_request(gst_pkg::FUNC_CREATE, 10'd0, 16'd0, 32'hA5A5_5A5A);
        send_request(gst_pkg::FUNC_LOOKUP, 10'd0, 16'd1, 32'd0);
        send_request(gst_pkg::FUNC_LOOKUP, 10'd0, 16'd2, 32'd0);
        send_request(gst_pkg::FUNC_LOOKUP, 10'd3, 16'd1, 32'd0);
        send_request(gst_pkg::FUNC_UPDATE, 10'd1, 16'd1, 32'h1234_5678);
        send_request(gst_pkg::FUNC_LOOKUP, 10'd1, 16'd1, 32'd0);
        send_request(gst_pkg::FUNC_REMOVE, 10'd0, 16'd1, 32'd0);
        send_request(gst_pkg::FUNC_LOOKUP, 10'd0, 16'd1, 32'd0);
        send_request(gst_pkg::FUNC_LOOKUP, 10'd2, 16'd1, 32'd0);
        send_request(gst_pkg::FUNC_REMOVE, 10'd0, 16'd1, 32'd0);
        send_request(gst_pkg::FUNC_UPDATE, 10'd0, 16'd1, 32'd5);
        send_request(gst_pkg::FUNC_CREATE, 10'd0, 16'd0, 32'hFFFF_0000);
        send_request(gst_pkg::FUNC_LOOKUP, 10'd0, 16'd2, 32'd0);
        send_request(gst_pkg::FUNC_REMOVE, 10'd2, 16'd1, 32'd0);
        send_request(gst_pkg::FUNC_REMOVE, 10'd1, 16'd1, 32'd0);
        send_request(gst_pkg::FUNC_REMOVE, 10'd0, 16'd2, 32'd0);
    endtask

    // mixed churn on a nearly empty table, reusing freed slots
    task automatic test_generation_wrap();
        int k;
        for (k = 0; k < 70; k++) random_op(50);
        wait_drained();
    endtask

    task automatic test_random(int n, int create_pct);
        int k;
        for (k = 0; k < n; k++) random_op(create_pct);
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        hold_off_go = 1'b1;
        test_random(40, 40);
        wait_drained();
    endtask

    // result checker
    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected result", 32'd0, 32'd0);
            end else begin
                want = pending_outcomes.pop_front();
                if (m_tuser != want.status)
                    report_mismatch("status", 32'(m_tuser), 32'(want.status));
                if (m_tdata[9:0] != want.slot)
                    report_mismatch("slot", 32'(m_tdata[9:0]), 32'(want.slot));
                if (m_tdata[25:10] != want.gen)
                    report_mismatch("gen", 32'(m_tdata[25:10]), 32'(want.gen));
                if (m_tdata[35:26] != want.pos)
                    report_mismatch("pos", 32'(m_tdata[35:26]), 32'(want.pos));
                if (m_tdata[67:36] != want.payload)
                    report_mismatch("payload", m_tdata[67:36], want.payload);
                if (m_tdata[78:68] != want.live)
                    report_mismatch("live", 32'(m_tdata[78:68]), 32'(want.live));
            end
        end
    end

    // receiver ready, with random stalls and one long hold-off on request
    always @(posedge aclk) begin
        if (hold_off_go && !hold_off_used) begin
            hold_off_used   <= 1'b1;
            hold_off_cycles <= HOLD_OFF_LEN - 1;
            m_tready        <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("generational_slot_table verification failed");
            $finish;
        end
    end

    initial begin
        int k;
        aclk = 0; aresetn = 0; s_tvalid = 0; s_tdata = '0; s_tuser = '0;
        sender_idle_pct = 0; receiver_stall_pct = 0;
        tbl_issued = '0; tbl_free_depth = '0; tbl_count = '0;
        for (k = 0; k < gst_pkg::NUM_SLOTS; k++) tbl_live[k] = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_generation_wrap();
        sender_idle_pct = 54; receiver_stall_pct = 0;  test_random(220, 55);
        sender_idle_pct = 0;  receiver_stall_pct = 54; test_random(220, 45);
        sender_idle_pct = 11; receiver_stall_pct = 11; test_random(220, 50);
        test_backpressure();
        sender_idle_pct = 0;  receiver_stall_pct = 0;  test_random(160, 50);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("generational_slot_table verification clean");
        end else begin
            $display("generational_slot_table verification failed");
        end
        $finish;
    end
endmodule
